/* rtl/lgcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_pkg
// Shared widths, fixed-point constants and the coefficient ROM of the
// leg-length LQR gain scheduler.
// ----------------------------------------------------------------------------
package lgcs_pkg;

  localparam int LEN_W          = 16;
  localparam int CF_BITS        = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_SHIFT     = CF_BITS - GAIN_FRAC_BITS;
  localparam int GAIN_W         = 26;

  localparam int ROWS  = 2;
  localparam int COLS  = 6;
  localparam int TERMS = 4;
  localparam int STEPS = TERMS - 1;
  localparam int COL_W = 3;
  localparam int K_IDX_W = 2;

  // normalization: x = rnd((len - center) * K / 2^32), K split in two halves
  localparam int D_W       = LEN_W + 1;
  localparam int K_W       = 43;
  localparam int K_SPLIT   = 22;
  localparam int K_HI_W    = K_W - K_SPLIT;
  localparam int P_LO_W    = D_W + K_SPLIT + 1;
  localparam int P_HI_W    = D_W + K_HI_W + 1;
  localparam int SUM_W     = D_W + K_W + 1;
  localparam int NRM_SHIFT = 32;
  localparam int XU_W      = SUM_W - NRM_SHIFT;
  localparam int X_W       = 25;

  localparam logic signed [D_W-1:0] CENTER_Q16 = 17'sd16384;
  localparam logic [K_W-1:0]        RECIP_K    = 43'd7330077518507;
  localparam logic [K_SPLIT-1:0]    K_LO       = RECIP_K[K_SPLIT-1:0];
  localparam logic [K_HI_W-1:0]     K_HI       = RECIP_K[K_W-1:K_SPLIT];
  localparam logic signed [SUM_W-1:0] NRM_RND  = SUM_W'(1) <<< (NRM_SHIFT - 1);
  localparam logic signed [X_W-1:0] X_MIN      = -25'sd10779921;
  localparam logic signed [X_W-1:0] X_MAX      = 25'sd6823853;

  // Horner datapath
  localparam int COEF_W = 32;
  localparam int ACC_W  = 34;
  localparam int PROD_W = ACC_W + X_W;
  localparam logic signed [PROD_W-1:0] STEP_RND = PROD_W'(1) <<< (CF_BITS - 1);
  localparam logic signed [ACC_W-1:0]  GAIN_RND =
    (GAIN_SHIFT == 0) ? ACC_W'(0) : (ACC_W'(1) <<< (GAIN_SHIFT - 1));
  localparam logic signed [ACC_W-1:0]  GAIN_MAX = ACC_W'(33554431);
  localparam logic signed [ACC_W-1:0]  GAIN_MIN = -ACC_W'(33554432);

  typedef struct packed {
    logic             row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

  // Q.24 coefficients, highest power first
  localparam logic signed [COEF_W-1:0] COEF [ROWS][COLS][TERMS] = '{
    '{
      '{-10367194, 25832607, -52813567, -271611560},
      '{232460, 314506, -5249446, -17985962},
      '{-6816372, 13843558, -17393347, -71530630},
      '{-3853484, 8282648, -12470713, -51372524},
      '{12302521, 25957780, -85170978, 109809486},
      '{-66919, 3495124, -10081155, 13345220}
    },
    '{
      '{53470970, 95572829, -367043870, 558512049},
      '{-1334387, 6964692, -18669290, 36168709},
      '{21577220, 69013675, -222038143, 339614163},
      '{10397108, 45513701, -140959142, 222136835},
      '{126717948, -291973607, 363681811, 2053996732},
      '{18519360, -31150353, 34789287, 87857641}
    }
  };

endpackage
`default_nettype wire

/* rtl/lgcs_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_in_if
// Leg-length input channel, valid/ready.
// ----------------------------------------------------------------------------
interface lgcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [lgcs_pkg::LEN_W-1:0] len_q16;

  modport source (output valid, output len_q16, input ready);
  modport sink   (input valid, input len_q16, output ready);
endinterface
`default_nettype wire

/* rtl/lgcs_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_out_if
// Gain output channel, valid/ready, one matrix element per transaction.
// ----------------------------------------------------------------------------
interface lgcs_out_if;
  logic                               valid;
  logic                               ready;
  logic                               control_row;
  logic [lgcs_pkg::COL_W-1:0]         state_column;
  logic signed [lgcs_pkg::GAIN_W-1:0] gain;
  logic                               last;

  modport source (output valid, output control_row, output state_column,
                  output gain, output last, input ready);
  modport sink   (input valid, input control_row, input state_column,
                  input gain, input last, output ready);
endinterface
`default_nettype wire

/* rtl/lgcs_norm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_norm
// Two-stage normalization: split multiply by the reciprocal, then
// recombine, round and clamp to the scheduled span.
// ----------------------------------------------------------------------------
module lgcs_norm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lgcs_in_if.sink                                in_s,
  output logic                                   nx_valid,
  input  wire logic                              nx_ready,
  output logic signed [lgcs_pkg::X_W-1:0]        nx
);

  logic                                  s1_v_r;
  logic signed [lgcs_pkg::P_LO_W-1:0]    p_lo_r, p_lo_nxt;
  logic signed [lgcs_pkg::P_HI_W-1:0]    p_hi_r, p_hi_nxt;
  logic                                  s2_v_r;
  logic signed [lgcs_pkg::X_W-1:0]       x_r, x_nxt;
  logic signed [lgcs_pkg::D_W-1:0]       d;
  logic signed [lgcs_pkg::SUM_W-1:0]     sum;
  logic signed [lgcs_pkg::XU_W-1:0]      xu;
  logic                                  s1_adv, s2_adv;

  assign s2_adv     = !s2_v_r || nx_ready;
  assign s1_adv     = !s1_v_r || s2_adv;
  assign in_s.ready = s1_adv;
  assign nx_valid   = s2_v_r;
  assign nx         = x_r;

  always_comb begin
    d        = $signed({1'b0, in_s.len_q16}) - lgcs_pkg::CENTER_Q16;
    p_lo_nxt = d * $signed({1'b0, lgcs_pkg::K_LO});
    p_hi_nxt = d * $signed({1'b0, lgcs_pkg::K_HI});
  end

  always_comb begin
    sum = (lgcs_pkg::SUM_W'(p_hi_r) <<< lgcs_pkg::K_SPLIT)
        + lgcs_pkg::SUM_W'(p_lo_r) + lgcs_pkg::NRM_RND;
    xu  = $signed(sum[lgcs_pkg::SUM_W-1:lgcs_pkg::NRM_SHIFT]);
    if (xu < lgcs_pkg::X_MIN) begin
      x_nxt = lgcs_pkg::X_MIN;
    end else if (xu > lgcs_pkg::X_MAX) begin
      x_nxt = lgcs_pkg::X_MAX;
    end else begin
      x_nxt = lgcs_pkg::X_W'(xu);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= in_s.valid;
      if (s2_adv) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
    end
    if (s2_adv) x_r <= x_nxt;
  end

endmodule
`default_nettype wire

/* rtl/lgcs_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_seq
// Holds one normalized length and issues the twelve matrix elements,
// row-major, one per cycle while the Horner pipeline accepts them.
// ----------------------------------------------------------------------------
module lgcs_seq (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              up_valid,
  output logic                                   up_ready,
  input  wire logic signed [lgcs_pkg::X_W-1:0]   up_x,
  output logic                                   dn_valid,
  input  wire logic                              dn_ready,
  output lgcs_pkg::tag_t                         dn_tag,
  output logic signed [lgcs_pkg::X_W-1:0]        dn_x
);

  logic                               v_r;
  logic                               row_r;
  logic [lgcs_pkg::COL_W-1:0]         col_r;
  logic signed [lgcs_pkg::X_W-1:0]    x_r;
  logic                               col_end, is_last, load;

  assign col_end  = (col_r == lgcs_pkg::COL_W'(lgcs_pkg::COLS - 1));
  assign is_last  = row_r && col_end;
  assign up_ready = !v_r || (dn_ready && is_last);
  assign load     = up_valid && up_ready;

  assign dn_valid    = v_r;
  assign dn_x        = x_r;
  assign dn_tag.row  = row_r;
  assign dn_tag.col  = col_r;
  assign dn_tag.last = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      row_r <= 1'b0;
      col_r <= '0;
    end else if (up_ready) begin
      v_r   <= up_valid;
      row_r <= 1'b0;
      col_r <= '0;
    end else if (dn_ready) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) x_r <= up_x;
  end

endmodule
`default_nettype wire

/* rtl/lgcs_horner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_horner
// Shared Horner pipeline: coefficient fetch, then per step a multiply stage
// and a round-and-add stage, then gain rounding and saturation into the
// output register.
// ----------------------------------------------------------------------------
module lgcs_horner (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lgcs_pkg::tag_t                    in_tag,
  input  wire logic signed [lgcs_pkg::X_W-1:0]   in_x,
  lgcs_out_if.source                             out_m
);

  localparam int STEPS = lgcs_pkg::STEPS;

  // coefficient fetch stage
  logic                                  c0_v_r;
  lgcs_pkg::tag_t                        c0_tag_r;
  logic signed [lgcs_pkg::X_W-1:0]       c0_x_r;
  logic signed [lgcs_pkg::ACC_W-1:0]     c0_acc_r;

  // multiply stages
  logic [STEPS-1:0]                      m_v_r;
  lgcs_pkg::tag_t                        m_tag_r  [STEPS];
  logic signed [lgcs_pkg::X_W-1:0]       m_x_r    [STEPS];
  logic signed [lgcs_pkg::PROD_W-1:0]    m_prod_r [STEPS];

  // round-and-add stages
  logic [STEPS-1:0]                      a_v_r;
  lgcs_pkg::tag_t                        a_tag_r  [STEPS];
  logic signed [lgcs_pkg::X_W-1:0]       a_x_r    [STEPS];
  logic signed [lgcs_pkg::ACC_W-1:0]     a_acc_r  [STEPS];
  logic signed [lgcs_pkg::ACC_W-1:0]     a_nxt    [STEPS];

  // multiply stage sources
  logic [STEPS-1:0]                      ms_v;
  lgcs_pkg::tag_t                        ms_tag   [STEPS];
  logic signed [lgcs_pkg::X_W-1:0]       ms_x     [STEPS];
  logic signed [lgcs_pkg::ACC_W-1:0]     ms_acc   [STEPS];

  // output register
  logic                                  g_v_r;
  lgcs_pkg::tag_t                        g_tag_r;
  logic signed [lgcs_pkg::GAIN_W-1:0]    g_gain_r, g_gain_nxt;
  logic signed [lgcs_pkg::ACC_W-1:0]     g_rs;

  logic                                  g_adv, c0_adv;
  logic [STEPS-1:0]                      m_adv, a_adv;
  logic signed [lgcs_pkg::PROD_W-1:0]    rs [STEPS];

  // backward advance chain
  always_comb begin
    g_adv            = !g_v_r || out_m.ready;
    a_adv[STEPS-1]   = !a_v_r[STEPS-1] || g_adv;
    m_adv[STEPS-1]   = !m_v_r[STEPS-1] || a_adv[STEPS-1];
    for (int j = STEPS - 2; j >= 0; j--) begin
      a_adv[j] = !a_v_r[j] || m_adv[j+1];
      m_adv[j] = !m_v_r[j] || a_adv[j];
    end
    c0_adv = !c0_v_r || m_adv[0];
  end

  assign in_ready = c0_adv;

  always_comb begin
    ms_v[0]   = c0_v_r;
    ms_tag[0] = c0_tag_r;
    ms_x[0]   = c0_x_r;
    ms_acc[0] = c0_acc_r;
    for (int j = 1; j < STEPS; j++) begin
      ms_v[j]   = a_v_r[j-1];
      ms_tag[j] = a_tag_r[j-1];
      ms_x[j]   = a_x_r[j-1];
      ms_acc[j] = a_acc_r[j-1];
    end
  end

  // acc = rnd(acc * x / 2^24) + c
  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      rs[j]    = m_prod_r[j] + lgcs_pkg::STEP_RND;
      a_nxt[j] = $signed(rs[j][lgcs_pkg::CF_BITS+lgcs_pkg::ACC_W-1:lgcs_pkg::CF_BITS])
               + lgcs_pkg::ACC_W'(lgcs_pkg::COEF[m_tag_r[j].row][m_tag_r[j].col]
                                                [lgcs_pkg::K_IDX_W'(j + 1)]);
    end
  end

  always_comb begin
    g_rs = (a_acc_r[STEPS-1] + lgcs_pkg::GAIN_RND) >>> lgcs_pkg::GAIN_SHIFT;
    if (g_rs > lgcs_pkg::GAIN_MAX) begin
      g_gain_nxt = lgcs_pkg::GAIN_W'(lgcs_pkg::GAIN_MAX);
    end else if (g_rs < lgcs_pkg::GAIN_MIN) begin
      g_gain_nxt = lgcs_pkg::GAIN_W'(lgcs_pkg::GAIN_MIN);
    end else begin
      g_gain_nxt = lgcs_pkg::GAIN_W'(g_rs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_v_r <= 1'b0;
      m_v_r  <= '0;
      a_v_r  <= '0;
      g_v_r  <= 1'b0;
    end else begin
      if (c0_adv) c0_v_r <= in_valid;
      for (int j = 0; j < STEPS; j++) begin
        if (m_adv[j]) m_v_r[j] <= ms_v[j];
        if (a_adv[j]) a_v_r[j] <= m_v_r[j];
      end
      if (g_adv) g_v_r <= a_v_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (c0_adv) begin
      c0_tag_r <= in_tag;
      c0_x_r   <= in_x;
      c0_acc_r <= lgcs_pkg::ACC_W'(lgcs_pkg::COEF[in_tag.row][in_tag.col][0]);
    end
    for (int j = 0; j < STEPS; j++) begin
      if (m_adv[j]) begin
        m_tag_r[j]  <= ms_tag[j];
        m_x_r[j]    <= ms_x[j];
        m_prod_r[j] <= ms_acc[j] * ms_x[j];
      end
      if (a_adv[j]) begin
        a_tag_r[j] <= m_tag_r[j];
        a_x_r[j]   <= m_x_r[j];
        a_acc_r[j] <= a_nxt[j];
      end
    end
    if (g_adv) begin
      g_tag_r  <= a_tag_r[STEPS-1];
      g_gain_r <= g_gain_nxt;
    end
  end

  assign out_m.valid        = g_v_r;
  assign out_m.control_row  = g_tag_r.row;
  assign out_m.state_column = g_tag_r.col;
  assign out_m.last         = g_tag_r.last;
  assign out_m.gain         = g_gain_r;

endmodule
`default_nettype wire

/* rtl/lqr_gain_cubic_schedule.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lqr_gain_cubic_schedule
// Leg-length LQR gain scheduler. Each leg length (unsigned Q0.16 m) is
// normalized to x = (L - 0.25) / 0.15 in Q.24, clamped to the span for
// 0.15362..0.31101 m, and yields twelve gains (row 0 columns 0..5, then
// row 1) as signed Q9.16 values saturated to 26 bits, the twelfth flagged
// by last. Each gain is a cubic in x evaluated by Horner's rule on ROM
// coefficients. One gain leaves per cycle, while the output is ready, through
// a single shared Horner pipeline; a new length is taken while the previous
// matrix is still draining. From an input transaction to the first gain the
// data passes two normalization stages, the issue register, coefficient
// fetch, three multiply and three round-and-add stages, and the gain
// output register.
// ----------------------------------------------------------------------------
module lqr_gain_cubic_schedule (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lgcs_in_if.sink    in_s,
  lgcs_out_if.source out_m
);

  logic                              nx_valid;
  logic                              nx_ready;
  logic signed [lgcs_pkg::X_W-1:0]   nx;
  logic                              tok_valid;
  logic                              tok_ready;
  lgcs_pkg::tag_t                    tok_tag;
  logic signed [lgcs_pkg::X_W-1:0]   tok_x;

  lgcs_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_s),
    .nx_valid (nx_valid),
    .nx_ready (nx_ready),
    .nx       (nx)
  );

  lgcs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (nx_valid),
    .up_ready (nx_ready),
    .up_x     (nx),
    .dn_valid (tok_valid),
    .dn_ready (tok_ready),
    .dn_tag   (tok_tag),
    .dn_x     (tok_x)
  );

  lgcs_horner u_horner (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (tok_valid),
    .in_ready (tok_ready),
    .in_tag   (tok_tag),
    .in_x     (tok_x),
    .out_m    (out_m)
  );

`ifndef SYNTH
  a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    nx_valid |-> (nx >= lgcs_pkg::X_MIN) && (nx <= lgcs_pkg::X_MAX))
    else $error("normalized length outside clamp span");

  a_tok_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    tok_valid |-> tok_tag.col <= lgcs_pkg::COL_W'(lgcs_pkg::COLS - 1))
    else $error("issued column out of range");

  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid |-> out_m.last == (out_m.control_row &&
      out_m.state_column == lgcs_pkg::COL_W'(lgcs_pkg::COLS - 1)))
    else $error("last flag not on final matrix element");
`endif

endmodule
`default_nettype wire

/* dv/lqr_gain_cubic_schedule_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lqr_gain_cubic_schedule_tb
// Self-checking bench for the leg-length LQR gain scheduler. A directed
// table walks the clamp edges, the span center and field extremes; random
// leg lengths follow, mostly inside the scheduled span. Each accepted length
// is normalized and its twelve Horner gains predicted in fixed point; every
// gain transaction is checked in order against that prediction. Both
// channels idle in random bursts; the gain side holds off once for a long
// stretch and the length side pauses once until the matrix queue drains.
// ----------------------------------------------------------------------------
module lqr_gain_cubic_schedule_tb;

  localparam int     HOLD_CYCLES   = 300;
  localparam int     WATCHDOG_MAX  = 3000;
  localparam int     RANDOM_ITEMS  = 132;
  localparam int     TAIL_START    = 120;
  localparam int     DRAIN_AT      = 60;
  localparam int     HOLD_AFTER    = 600;
  localparam int     SETTLE_CYCLES = 24;

  localparam longint LEN_CENTER = 16384;
  localparam longint LEN_RECIP  = 64'sd7330077518507;
  localparam longint XN_MIN     = -64'sd10779921;
  localparam longint XN_MAX     = 64'sd6823853;
  localparam longint G_MAX      = 64'sd33554431;
  localparam longint G_MIN      = -64'sd33554432;
  localparam int     Q_BITS     = 24;

  localparam longint GAIN_POLY [2][6][4] = '{
    '{
      '{-10367194, 25832607, -52813567, -271611560},
      '{232460, 314506, -5249446, -17985962},
      '{-6816372, 13843558, -17393347, -71530630},
      '{-3853484, 8282648, -12470713, -51372524},
      '{12302521, 25957780, -85170978, 109809486},
      '{-66919, 3495124, -10081155, 13345220}
    },
    '{
      '{53470970, 95572829, -367043870, 558512049},
      '{-1334387, 6964692, -18669290, 36168709},
      '{21577220, 69013675, -222038143, 339614163},
      '{10397108, 45513701, -140959142, 222136835},
      '{126717948, -291973607, 363681811, 2053996732},
      '{18519360, -31150353, 34789287, 87857641}
    }
  };

  typedef struct {
    logic                               row;
    logic [lgcs_pkg::COL_W-1:0]         col;
    logic signed [lgcs_pkg::GAIN_W-1:0] gain;
    logic                               last;
  } gain_entry_t;

  typedef struct {
    logic [lgcs_pkg::LEN_W-1:0] len;
    bit                         pinned;
    longint                     x_norm;
  } length_row_t;

  localparam int N_DIRECTED = 18;
  length_row_t length_table [N_DIRECTED] = '{
    '{16'd0,     1'b1, XN_MIN},
    '{16'd65535, 1'b1, XN_MAX},
    '{16'd16384, 1'b1, 64'sd0},
    '{16'd1,     1'b1, XN_MIN},
    '{16'h8000,  1'b1, XN_MAX},
    '{16'h5555,  1'b1, XN_MAX},
    '{16'hAAAA,  1'b1, XN_MAX},
    '{16'd10067, 1'b1, XN_MIN},
    '{16'd10068, 1'b0, 64'sd0},
    '{16'd20382, 1'b0, 64'sd0},
    '{16'd20383, 1'b1, XN_MAX},
    '{16'd16383, 1'b0, 64'sd0},
    '{16'd16385, 1'b0, 64'sd0},
    '{16'h2AAA,  1'b0, 64'sd0},
    '{16'h3333,  1'b0, 64'sd0},
    '{16'h4CCC,  1'b0, 64'sd0},
    '{16'd12000, 1'b0, 64'sd0},
    '{16'h7FFF,  1'b1, XN_MAX}
  };

  logic clk;
  logic rst_n;

  lgcs_in_if  len_ch ();
  lgcs_out_if gain_ch ();

  lqr_gain_cubic_schedule DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (len_ch),
    .out_m (gain_ch)
  );

  gain_entry_t pending_gains[$];
  bit          note_pinned;
  longint      note_x;
  int          fail_count;
  int          mismatch_count;
  int          gains_seen;
  int          quiet_cycles;
  bit          tail_mode;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint normalize_length(input logic [lgcs_pkg::LEN_W-1:0] len);
    longint v;
    v = (longint'(len) - LEN_CENTER) * LEN_RECIP;
    v = (v + (64'sd1 <<< 31)) >>> 32;
    if (v < XN_MIN) v = XN_MIN;
    if (v > XN_MAX) v = XN_MAX;
    return v;
  endfunction

  function automatic void push_gain_matrix(input longint x);
    longint      acc;
    int          s;
    gain_entry_t e;
    s = Q_BITS - lgcs_pkg::GAIN_FRAC_BITS;
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 6; c++) begin
        acc = GAIN_POLY[r][c][0];
        for (int k = 1; k < 4; k++) begin
          acc = (((acc * x) + (64'sd1 <<< (Q_BITS - 1))) >>> Q_BITS)
              + GAIN_POLY[r][c][k];
        end
        if (s > 0) acc = (acc + (64'sd1 <<< (s - 1))) >>> s;
        if (acc > G_MAX) acc = G_MAX;
        if (acc < G_MIN) acc = G_MIN;
        e.row  = r[0];
        e.col  = c[lgcs_pkg::COL_W-1:0];
        e.gain = acc[lgcs_pkg::GAIN_W-1:0];
        e.last = (r == 1 && c == 5);
        pending_gains.push_back(e);
      end
    end
  endfunction

  // transaction monitor: check gains first, then queue the new matrix
  always @(posedge clk) begin
    gain_entry_t e;
    if (rst_n) begin
      if (gain_ch.valid && gain_ch.ready) begin
        gains_seen++;
        if (pending_gains.size() == 0) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("unexpected gain transaction: row %0d col %0d gain %0d last %0b",
                     gain_ch.control_row, gain_ch.state_column, gain_ch.gain,
                     gain_ch.last);
          mismatch_count++;
        end else begin
          e = pending_gains.pop_front();
          if (gain_ch.control_row !== e.row || gain_ch.state_column !== e.col ||
              gain_ch.gain !== e.gain || gain_ch.last !== e.last) begin
            fail_count++;
            if (mismatch_count < 10)
              $display({"gain mismatch: exp row %0d col %0d gain %0d last %0b, ",
                        "got row %0d col %0d gain %0d last %0b"},
                       e.row, e.col, e.gain, e.last, gain_ch.control_row,
                       gain_ch.state_column, gain_ch.gain, gain_ch.last);
            mismatch_count++;
          end
        end
      end
      if (len_ch.valid && len_ch.ready)
        push_gain_matrix(note_pinned ? note_x : normalize_length(len_ch.len_q16));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((len_ch.valid && len_ch.ready) || (gain_ch.valid && gain_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("[lqr_gain_cubic_schedule] ERROR");
        $finish;
      end
    end
  end

  // gain side: random back-pressure, one long hold-off, none in the tail
  initial begin
    bit held;
    held = 1'b0;
    gain_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!tail_mode && !held && gains_seen >= HOLD_AFTER) begin
        held = 1'b1;
        gain_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!tail_mode && $urandom_range(0, 4) == 0) begin
        gain_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      gain_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic drive_length(input logic [lgcs_pkg::LEN_W-1:0] len, input bit pinned,
                              input longint x);
    len_ch.valid   <= 1'b1;
    len_ch.len_q16 <= len;
    note_pinned    <= pinned;
    note_x         <= x;
    @(posedge clk);
    while (!len_ch.ready) @(posedge clk);
  endtask

  task automatic length_gap();
    if (!tail_mode && $urandom_range(0, 3) == 0) begin
      len_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_matrix_drain();
    len_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_gains.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [lgcs_pkg::LEN_W-1:0] len;
    fail_count        = 0;
    mismatch_count    = 0;
    gains_seen        = 0;
    quiet_cycles      = 0;
    tail_mode         = 1'b0;
    rst_n            <= 1'b0;
    len_ch.valid     <= 1'b0;
    len_ch.len_q16   <= '0;
    note_pinned      <= 1'b0;
    note_x           <= 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (length_table[i]) begin
      drive_length(length_table[i].len, length_table[i].pinned, length_table[i].x_norm);
      length_gap();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == TAIL_START) tail_mode = 1'b1;
      if (i == DRAIN_AT) wait_matrix_drain();
      // most lengths inside the scheduled span, some anywhere
      if ($urandom_range(0, 9) < 7)
        len = $urandom_range(10000, 20450);
      else
        len = $urandom_range(0, 65535);
      drive_length(len, 1'b0, 0);
      length_gap();
    end

    wait_matrix_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_gains.size() == 0) begin
      $display("[lqr_gain_cubic_schedule] OK");
    end else begin
      $display("[lqr_gain_cubic_schedule] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/lgcs_pkg.sv
rtl/lgcs_in_if.sv
rtl/lgcs_out_if.sv
rtl/lgcs_norm.sv
rtl/lgcs_seq.sv
rtl/lgcs_horner.sv
rtl/lqr_gain_cubic_schedule.sv
dv/lqr_gain_cubic_schedule_tb.sv
